// ===== sv/counting_sort_engine_defines.svh =====
// Assertion helpers used by the counting sort engine datapath.
`ifndef COUNTING_SORT_ENGINE_DEFINES_SVH
`define COUNTING_SORT_ENGINE_DEFINES_SVH

// The expression must hold at every clock edge outside reset.
`define CSE_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("counting sort engine check failed");

// The consequent must hold in the same cycle as the antecedent.
`define CSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("counting sort engine check failed");

`endif

// ===== sv/cse_pkg.sv =====
`default_nettype none

package cse_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int KEY_BINS  = 256;

  localparam int KEY_W    = 8;
  localparam int BIN_AW   = $clog2(KEY_BINS);
  localparam int BIN_IW   = BIN_AW + 1;
  localparam int ITEM_AW  = $clog2(MAX_ITEMS);
  localparam int CNT_W    = ITEM_AW + 1;
  localparam int LIM_W    = 9;
  localparam int STAT_W   = 2;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // Request type codes.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_PULL = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FLAGGED = 2'd2;

  // Register index of key_limit (word address bits of paddr).
  localparam logic [CFG_AW-3:0] REG_KEY_LIMIT = '0;
  localparam logic [LIM_W-1:0]  KEY_LIMIT_RST = LIM_W'(256);

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key_in;
    logic             last_key;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0]  sorted_key;
    logic              final_key;
    logic [STAT_W-1:0] status;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;
    logic pull;
    logic bin_upd;
    logic prefix_init;
    logic prefix_step;
    logic place_init;
    logic place_key;
    logic place_bin;
    logic place_wr;
    logic set_ready;
    logic pull_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic push_full;
    logic pull_avail;
    logic prefix_done;
    logic place_done;
    logic out_valid;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/cse_cfg.sv =====
`default_nettype none

module cse_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cse_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [cse_pkg::CFG_DW-1:0]    pwdata,
  output logic      [cse_pkg::CFG_DW-1:0]    prdata,
  output logic                               pready,
  output logic      [cse_pkg::LIM_W-1:0]     key_limit
);

  logic [cse_pkg::LIM_W-1:0] key_limit_r;
  logic [cse_pkg::LIM_W-1:0] key_limit_nxt;
  logic                      sel_lim;

  assign sel_lim = (paddr[cse_pkg::CFG_AW-1:2] == cse_pkg::REG_KEY_LIMIT);

  always_comb begin
    key_limit_nxt = key_limit_r;
    if (psel && penable && pwrite && sel_lim) begin
      key_limit_nxt = pwdata[cse_pkg::LIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_limit_r <= cse_pkg::KEY_LIMIT_RST;
    end else begin
      key_limit_r <= key_limit_nxt;
    end
  end

  assign prdata    = sel_lim ? cse_pkg::CFG_DW'(key_limit_r) : '0;
  assign pready    = 1'b1;
  assign key_limit = key_limit_r;

endmodule

`default_nettype wire

// ===== sv/cse_ctrl.sv =====
`default_nettype none

module cse_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire cse_pkg::in_t  in_data,
  output logic               in_stall,
  input  wire logic          out_stall,
  input  wire cse_pkg::sts_t sts,
  output cse_pkg::cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_PUSH_UPD = 3'd1;
  localparam logic [2:0] ST_PREFIX   = 3'd2;
  localparam logic [2:0] ST_PL_KEY   = 3'd3;
  localparam logic [2:0] ST_PL_BIN   = 3'd4;
  localparam logic [2:0] ST_PL_WR    = 3'd5;
  localparam logic [2:0] ST_PULL_RD  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       last_r;
  logic       last_nxt;
  logic       acc;

  assign in_stall = (state_r != ST_IDLE) || (sts.out_valid && out_stall);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_data.req_type == cse_pkg::REQ_PUSH) begin
            cmd.push = 1'b1;
            last_nxt = in_data.last_key;
            if (!sts.push_full) begin
              state_nxt = ST_PUSH_UPD;
            end else if (in_data.last_key) begin
              cmd.prefix_init = 1'b1;
              state_nxt       = ST_PREFIX;
            end
          end else begin
            cmd.pull = 1'b1;
            if (sts.pull_avail) begin
              state_nxt = ST_PULL_RD;
            end
          end
        end
      end
      ST_PUSH_UPD: begin
        cmd.bin_upd = 1'b1;
        if (last_r) begin
          cmd.prefix_init = 1'b1;
          state_nxt       = ST_PREFIX;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PREFIX: begin
        cmd.prefix_step = 1'b1;
        if (sts.prefix_done) begin
          cmd.place_init = 1'b1;
          state_nxt      = ST_PL_KEY;
        end
      end
      ST_PL_KEY: begin
        if (sts.place_done) begin
          cmd.set_ready = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.place_key = 1'b1;
          state_nxt     = ST_PL_BIN;
        end
      end
      ST_PL_BIN: begin
        cmd.place_bin = 1'b1;
        state_nxt     = ST_PL_WR;
      end
      ST_PL_WR: begin
        cmd.place_wr = 1'b1;
        state_nxt    = ST_PL_KEY;
      end
      ST_PULL_RD: begin
        cmd.pull_load = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cse_datapath.sv =====
`default_nettype none

module cse_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cse_pkg::cmd_t             cmd,
  output cse_pkg::sts_t                  sts,
  input  wire cse_pkg::in_t              in_data,
  input  wire logic [cse_pkg::LIM_W-1:0] key_limit,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output cse_pkg::out_t                  out_data
);

  `include "counting_sort_engine_defines.svh"

  localparam logic [cse_pkg::CNT_W-1:0]  MAX_CNT  = cse_pkg::CNT_W'(cse_pkg::MAX_ITEMS);
  localparam logic [cse_pkg::BIN_IW-1:0] BIN_END  = cse_pkg::BIN_IW'(cse_pkg::KEY_BINS);
  localparam logic [cse_pkg::LIM_W-1:0]  LIM_MAX  = cse_pkg::LIM_W'(cse_pkg::KEY_BINS);
  localparam logic [cse_pkg::LIM_W-1:0]  LIM_ONE  = cse_pkg::LIM_W'(1);

  // Memories.
  logic [cse_pkg::CNT_W-1:0] bin_mem    [cse_pkg::KEY_BINS];
  logic [cse_pkg::KEY_W-1:0] key_mem    [cse_pkg::MAX_ITEMS];
  logic [cse_pkg::KEY_W-1:0] sorted_mem [cse_pkg::MAX_ITEMS];

  logic [cse_pkg::CNT_W-1:0]    bin_rd_r;
  logic [cse_pkg::BIN_AW-1:0]   bin_rtag_r;
  logic [cse_pkg::KEY_W-1:0]    key_rd_r;
  logic [cse_pkg::KEY_W-1:0]    sorted_rd_r;

  // Set state.
  logic [cse_pkg::KEY_BINS-1:0] bin_vld_r;
  logic [cse_pkg::KEY_BINS-1:0] bin_vld_nxt;
  logic [cse_pkg::CNT_W-1:0]    cnt_r;
  logic [cse_pkg::CNT_W-1:0]    cnt_nxt;
  logic [cse_pkg::CNT_W-1:0]    rp_r;
  logic [cse_pkg::CNT_W-1:0]    rp_nxt;
  logic                         err_r;
  logic                         err_nxt;
  logic                         ready_r;
  logic                         ready_nxt;

  // Sort sequencing.
  logic [cse_pkg::BIN_IW-1:0]   idx_r;
  logic [cse_pkg::BIN_IW-1:0]   idx_nxt;
  logic                         pend_r;
  logic                         pend_nxt;
  logic [cse_pkg::CNT_W-1:0]    run_r;
  logic [cse_pkg::CNT_W-1:0]    run_nxt;
  logic [cse_pkg::CNT_W-1:0]    pi_r;
  logic [cse_pkg::CNT_W-1:0]    pi_nxt;

  // Output register.
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  cse_pkg::out_t                out_data_r;
  cse_pkg::out_t                out_data_nxt;

  logic [cse_pkg::LIM_W-1:0]    lim_eff;
  logic [cse_pkg::LIM_W-1:0]    lim_dec;
  logic                         sat;
  logic [cse_pkg::KEY_W-1:0]    key_sat;
  logic [cse_pkg::CNT_W-1:0]    cnt_eff;
  logic                         full;
  logic [cse_pkg::CNT_W-1:0]    bin_cur;
  logic [cse_pkg::CNT_W-1:0]    bin_dec;
  logic [cse_pkg::CNT_W-1:0]    run_sum;
  logic [cse_pkg::CNT_W-1:0]    pi_dec;
  logic [cse_pkg::CNT_W-1:0]    rp_inc;
  logic                         avail;

  logic                         bin_we;
  logic [cse_pkg::CNT_W-1:0]    bin_wdata;
  logic [cse_pkg::BIN_AW-1:0]   bin_raddr;
  logic                         key_we;
  logic                         sorted_we;

  // Effective key limit and key saturation.
  always_comb begin
    lim_eff = key_limit;
    if (key_limit == '0) begin
      lim_eff = LIM_ONE;
    end else if (key_limit > LIM_MAX) begin
      lim_eff = LIM_MAX;
    end
  end

  assign lim_dec = lim_eff - LIM_ONE;
  assign sat     = (cse_pkg::LIM_W'(in_data.key_in) >= lim_eff);
  assign key_sat = sat ? lim_dec[cse_pkg::KEY_W-1:0] : in_data.key_in;

  // A push after a finished sort starts from an empty set.
  assign cnt_eff = ready_r ? '0 : cnt_r;
  assign full    = (cnt_eff == MAX_CNT);

  // Bins never written in this set read as zero.
  assign bin_cur = bin_vld_r[bin_rtag_r] ? bin_rd_r : '0;
  assign bin_dec = bin_cur - cse_pkg::CNT_W'(1);
  assign run_sum = run_r + bin_cur;
  assign pi_dec  = pi_r - cse_pkg::CNT_W'(1);
  assign rp_inc  = rp_r + cse_pkg::CNT_W'(1);
  assign avail   = ready_r && (rp_r < cnt_r);

  always_comb begin
    bin_raddr = idx_r[cse_pkg::BIN_AW-1:0];
    if (cmd.push) begin
      bin_raddr = key_sat;
    end else if (cmd.place_bin) begin
      bin_raddr = key_rd_r;
    end
  end

  always_comb begin
    bin_we    = 1'b0;
    bin_wdata = bin_cur;
    if (cmd.bin_upd) begin
      bin_we    = 1'b1;
      bin_wdata = bin_cur + cse_pkg::CNT_W'(1);
    end else if (cmd.prefix_step && pend_r) begin
      bin_we    = 1'b1;
      bin_wdata = run_sum;
    end else if (cmd.place_wr && (bin_cur != '0)) begin
      bin_we    = 1'b1;
      bin_wdata = bin_dec;
    end
  end

  assign key_we    = cmd.push && !full;
  assign sorted_we = cmd.place_wr && (bin_cur != '0);

  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[bin_rtag_r] <= bin_wdata;
    end
    bin_rd_r   <= bin_mem[bin_raddr];
    bin_rtag_r <= bin_raddr;
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[cnt_eff[cse_pkg::ITEM_AW-1:0]] <= key_sat;
    end
    key_rd_r <= key_mem[pi_dec[cse_pkg::ITEM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (sorted_we) begin
      sorted_mem[bin_dec[cse_pkg::ITEM_AW-1:0]] <= bin_rtag_r;
    end
    sorted_rd_r <= sorted_mem[rp_r[cse_pkg::ITEM_AW-1:0]];
  end

  always_comb begin
    bin_vld_nxt   = bin_vld_r;
    cnt_nxt       = cnt_r;
    rp_nxt        = rp_r;
    err_nxt       = err_r;
    ready_nxt     = ready_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    run_nxt       = run_r;
    pi_nxt        = pi_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.push) begin
      if (ready_r) begin
        bin_vld_nxt = '0;
        rp_nxt      = '0;
        err_nxt     = 1'b0;
      end
      ready_nxt = 1'b0;
      cnt_nxt   = full ? cnt_eff : cnt_eff + cse_pkg::CNT_W'(1);
      if (sat || full) begin
        err_nxt = 1'b1;
      end
    end

    if (bin_we) begin
      bin_vld_nxt[bin_rtag_r] = 1'b1;
    end

    if (cmd.prefix_init) begin
      idx_nxt  = '0;
      pend_nxt = 1'b0;
      run_nxt  = '0;
    end else if (cmd.prefix_step) begin
      pend_nxt = (idx_r != BIN_END);
      if (idx_r != BIN_END) begin
        idx_nxt = idx_r + cse_pkg::BIN_IW'(1);
      end
      if (pend_r) begin
        run_nxt = run_sum;
      end
    end

    if (cmd.place_init) begin
      pi_nxt = cnt_r;
    end else if (cmd.place_key) begin
      pi_nxt = pi_dec;
    end

    if (cmd.set_ready) begin
      ready_nxt = 1'b1;
      rp_nxt    = '0;
    end

    if (cmd.pull) begin
      if (avail) begin
        rp_nxt                 = rp_inc;
        out_data_nxt.final_key = (rp_inc == cnt_r);
        out_data_nxt.status    = err_r ? cse_pkg::STAT_FLAGGED : cse_pkg::STAT_OK;
      end else begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.sorted_key = '0;
        out_data_nxt.final_key  = 1'b0;
        out_data_nxt.status     = cse_pkg::STAT_EMPTY;
      end
    end

    if (cmd.pull_load) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.sorted_key = sorted_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_vld_r   <= '0;
      cnt_r       <= '0;
      rp_r        <= '0;
      err_r       <= 1'b0;
      ready_r     <= 1'b0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      run_r       <= '0;
      pi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bin_vld_r   <= bin_vld_nxt;
      cnt_r       <= cnt_nxt;
      rp_r        <= rp_nxt;
      err_r       <= err_nxt;
      ready_r     <= ready_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      run_r       <= run_nxt;
      pi_r        <= pi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign sts.push_full   = full;
  assign sts.pull_avail  = avail;
  assign sts.prefix_done = (idx_r == BIN_END) && !pend_r;
  assign sts.place_done  = (pi_r == '0);
  assign sts.out_valid   = out_valid_r;

  // The set never holds more keys than the key store.
  `CSE_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= MAX_CNT)
  // Reads never run past the keys of the set.
  `CSE_ASSERT_ALWAYS(a_rp_bound, clk, rst_n, rp_r <= cnt_r)
  // The running sum over the histogram equals the number of stored keys.
  `CSE_ASSERT_IMPLY(a_prefix_total, clk, rst_n, cmd.place_init, run_r == cnt_r)
  // Every key placed finds a nonzero position in its bin.
  `CSE_ASSERT_IMPLY(a_place_pos, clk, rst_n, cmd.place_wr, bin_cur != '0)

endmodule

`default_nettype wire

// ===== sv/counting_sort_engine.sv =====
// A push beat is accepted, then updates the histogram unless the set is full; a pull
//   beat with nothing ready loads its empty status into the output register directly,
//   else it reads the sorted store first. The last key adds a prefix sweep over all
//   bins, a key fetch, bin read and bin write per stored key, and a closing step.
// No beat is taken before the last is done; empty pulls go every cycle while out_stall is low.
// Reset (rst_n low, synchronous) clears counters, error flag and bin valid bits; key_limit=256.
`default_nettype none

module counting_sort_engine (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input channel: push and pull requests.
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire cse_pkg::in_t                    in_data,
  // Result channel: one beat per pull.
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output cse_pkg::out_t                        out_data,
  // Configuration port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [cse_pkg::CFG_AW-1:0]      paddr,
  input  wire logic [cse_pkg::CFG_DW-1:0]      pwdata,
  output logic      [cse_pkg::CFG_DW-1:0]      prdata,
  output logic                                 pready
);

  // The block works on one request at a time. The controller sequences the push
  // update, the prefix sweep over all bins and the back-to-front placement; the
  // datapath owns the histogram (one registered read port and one write port),
  // the key store, the sorted store and the output register.
  //
  // Histogram bins carry a valid bit each, so starting a new set clears the whole
  // histogram at once by clearing the valid bits: a bin that is not valid reads as zero.
  //
  // A pull beat is accepted while the output register is empty or being drained.
  // A pull with nothing to read returns its empty status straight away; a pull with
  // data reads the sorted store into a register and then loads the output register from it.

  logic [cse_pkg::LIM_W-1:0] key_limit;
  cse_pkg::cmd_t             cmd;
  cse_pkg::sts_t             sts;

  cse_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .key_limit (key_limit)
  );

  cse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cse_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .key_limit (key_limit),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
